// File: rtl/core/assert_macros.svh
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/qmr_pkg.sv
// types, constants and term tables for the quaternion multiply/rotate unit
`timescale 1ns / 1ps
`default_nettype none
package qmr_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int COMP_W        = 32;
   localparam int OPND_W        = COMP_W + 1;
   localparam int PROD_W        = 2 * OPND_W;
   localparam int NUM_C         = 4;

   localparam logic OP_MUL = 1'b0;
   localparam logic OP_ROT = 1'b1;

   typedef logic signed [COMP_W-1:0] comp_type;
   typedef logic signed [OPND_W-1:0] opnd_type;
   typedef comp_type quat_type [NUM_C];
   typedef opnd_type opnd_quat_type [NUM_C];

   typedef struct packed {
      logic valid;
      logic op;
   } ctl_type;

   typedef logic [1:0] idx_type;
   typedef idx_type term_idx_type [NUM_C][NUM_C];
   typedef logic term_neg_type [NUM_C][NUM_C];

   // component i of p*q is the sum over n of +/- p[n] * q[Q_IDX[i][n]]
   localparam term_idx_type Q_IDX = '{
      '{2'd0, 2'd1, 2'd2, 2'd3},
      '{2'd1, 2'd0, 2'd3, 2'd2},
      '{2'd2, 2'd3, 2'd0, 2'd1},
      '{2'd3, 2'd2, 2'd1, 2'd0}
   };

   localparam term_neg_type Q_NEG = '{
      '{1'b0, 1'b1, 1'b1, 1'b1},
      '{1'b0, 1'b0, 1'b0, 1'b1},
      '{1'b0, 1'b1, 1'b0, 1'b0},
      '{1'b0, 1'b0, 1'b1, 1'b0}
   };

endpackage
`default_nettype wire

// File: rtl/core/quaternion_multiply_rotate.sv
// quaternion multiply / rotate: input register, both hamilton units, output register
// throughput one request per cycle, busy is always low, results cannot be stalled
// rotation runs through two chained three-stage hamilton units, multiply bypasses the second
// synchronous reset clears the valid pipeline; data registers are not reset
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module quaternion_multiply_rotate import qmr_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic                     req_op,
   input  wire logic signed [COMP_W-1:0] req_a_w,
   input  wire logic signed [COMP_W-1:0] req_a_x,
   input  wire logic signed [COMP_W-1:0] req_a_y,
   input  wire logic signed [COMP_W-1:0] req_a_z,
   input  wire logic signed [COMP_W-1:0] req_b_w,
   input  wire logic signed [COMP_W-1:0] req_b_x,
   input  wire logic signed [COMP_W-1:0] req_b_y,
   input  wire logic signed [COMP_W-1:0] req_b_z,
   output logic                          rsp_valid,
   output logic signed [COMP_W-1:0]      rsp_r_w,
   output logic signed [COMP_W-1:0]      rsp_r_x,
   output logic signed [COMP_W-1:0]      rsp_r_y,
   output logic signed [COMP_W-1:0]      rsp_r_z
);

   ctl_type       in_ctl_in, in_ctl_ff;
   opnd_quat_type a_in, a_ff, q_in, q_ff;
   quat_type      b_in, b_ff;

   ctl_type       u1_ctl, u2_ctl;
   quat_type      t1, b1;
   quat_type      rot, t2;
   opnd_quat_type p2, q2;

   logic          out_valid_ff;
   quat_type      out_in, out_ff;

   // the pipeline never stalls
   assign busy = 1'b0;

   assign in_ctl_in = '{valid: start && !busy, op: req_op};

   always_comb begin
      b_in = '{req_b_w, req_b_x, req_b_y, req_b_z};
      a_in = '{opnd_type'(req_a_w), opnd_type'(req_a_x),
               opnd_type'(req_a_y), opnd_type'(req_a_z)};
      q_in[0] = opnd_type'(req_b_w);
      for (int n = 1; n < NUM_C; n++) begin
         // conjugate at full width so the most negative value does not wrap
         q_in[n] = (req_op == OP_ROT) ? -opnd_type'(b_in[n]) : opnd_type'(b_in[n]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ctl_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         in_ctl_ff    <= in_ctl_in;
         out_valid_ff <= u2_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      q_ff   <= q_in;
      b_ff   <= b_in;
      out_ff <= out_in;
   end

   qmr_hamilton #(.FRAC_BITS(FRAC_BITS)) u_first (
      .clock    (clock),
      .reset    (reset),
      .ctl_in   (in_ctl_ff),
      .p_in     (a_ff),
      .q_in     (q_ff),
      .side_in  (b_ff),
      .ctl_out  (u1_ctl),
      .r_out    (t1),
      .side_out (b1)
   );

   always_comb begin
      for (int n = 0; n < NUM_C; n++) begin
         p2[n] = opnd_type'(b1[n]);
         q2[n] = opnd_type'(t1[n]);
      end
   end

   qmr_hamilton #(.FRAC_BITS(FRAC_BITS)) u_second (
      .clock    (clock),
      .reset    (reset),
      .ctl_in   (u1_ctl),
      .p_in     (p2),
      .q_in     (q2),
      .side_in  (t1),
      .ctl_out  (u2_ctl),
      .r_out    (rot),
      .side_out (t2)
   );

   assign out_in = (u2_ctl.op == OP_ROT) ? rot : t2;

   assign rsp_valid = out_valid_ff;
   assign rsp_r_w   = out_ff[0];
   assign rsp_r_x   = out_ff[1];
   assign rsp_r_y   = out_ff[2];
   assign rsp_r_z   = out_ff[3];

   `ASSERT_NEXT(a_req_enters, clock, reset, start && !busy, in_ctl_ff.valid)
   `ASSERT_NEXT(a_second_to_out, clock, reset, u2_ctl.valid, rsp_valid)
   `ASSERT_NEXT(a_mul_bypass, clock, reset, u2_ctl.valid && u2_ctl.op == OP_MUL, rsp_r_x == $past(t2[1]))

endmodule
`default_nettype wire

// File: rtl/core/qmr_hamilton.sv
// three-stage hamilton product: multiply, round, sum and saturate
`timescale 1ns / 1ps
`default_nettype none
module qmr_hamilton import qmr_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ctl_type       ctl_in,
   input  wire opnd_quat_type p_in,
   input  wire opnd_quat_type q_in,
   input  wire quat_type      side_in,
   output ctl_type            ctl_out,
   output quat_type           r_out,
   output quat_type           side_out
);

   localparam int RND_W = PROD_W - FRAC_BITS;
   localparam int SUM_W = RND_W + 2;
   localparam logic signed [PROD_W-1:0] HALF =
      {{(PROD_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

   ctl_type ctl1_ff, ctl2_ff, ctl3_ff;
   quat_type side1_ff, side2_ff, side3_ff;

   logic signed [PROD_W-1:0] prod_in [NUM_C][NUM_C];
   logic signed [PROD_W-1:0] prod_ff [NUM_C][NUM_C];
   logic signed [PROD_W-1:0] shifted [NUM_C][NUM_C];
   logic signed [RND_W-1:0]  rnd_in  [NUM_C][NUM_C];
   logic signed [RND_W-1:0]  rnd_ff  [NUM_C][NUM_C];
   logic signed [SUM_W-1:0]  sum_c   [NUM_C];
   comp_type                 res_in  [NUM_C];
   comp_type                 res_ff  [NUM_C];

   always_comb begin
      for (int i = 0; i < NUM_C; i++) begin
         for (int n = 0; n < NUM_C; n++) begin
            prod_in[i][n] = PROD_W'($signed(p_in[n])) * PROD_W'($signed(q_in[Q_IDX[i][n]]));
         end
      end
   end

   // round to nearest, ties toward plus infinity (floor after adding half)
   always_comb begin
      for (int i = 0; i < NUM_C; i++) begin
         for (int n = 0; n < NUM_C; n++) begin
            shifted[i][n] = (prod_ff[i][n] + HALF) >>> FRAC_BITS;
            rnd_in[i][n]  = shifted[i][n][RND_W-1:0];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_C; i++) begin
         sum_c[i] = '0;
         for (int n = 0; n < NUM_C; n++) begin
            if (Q_NEG[i][n]) begin
               sum_c[i] = sum_c[i] - SUM_W'(rnd_ff[i][n]);
            end else begin
               sum_c[i] = sum_c[i] + SUM_W'(rnd_ff[i][n]);
            end
         end
         // in range when the result sign bit and all bits above it agree
         if (sum_c[i][SUM_W-1:COMP_W-1] == '0 || sum_c[i][SUM_W-1:COMP_W-1] == '1) begin
            res_in[i] = sum_c[i][COMP_W-1:0];
         end else if (sum_c[i][SUM_W-1]) begin
            res_in[i] = {1'b1, {(COMP_W-1){1'b0}}};
         end else begin
            res_in[i] = {1'b0, {(COMP_W-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
      end else begin
         ctl1_ff <= ctl_in;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      rnd_ff   <= rnd_in;
      res_ff   <= res_in;
      side1_ff <= side_in;
      side2_ff <= side1_ff;
      side3_ff <= side2_ff;
   end

   assign ctl_out  = ctl3_ff;
   assign r_out    = res_ff;
   assign side_out = side3_ff;

endmodule
`default_nettype wire

// File: verif/quaternion_multiply_rotate_tb.sv
// testbench for the quaternion multiply/rotate unit: directed and random requests, self-checking
`timescale 1ns / 1ps
module quaternion_multiply_rotate_tb;
   import qmr_pkg::*;

   localparam int FRAC = FRAC_BITS_DEF;
   localparam int WATCHDOG_LIMIT = 1000;

   localparam comp_type ZERO      = 32'sh0000_0000;
   localparam comp_type ONE       = 32'sh0001_0000;
   localparam comp_type HALF      = 32'sh0000_8000;
   localparam comp_type LSB       = 32'sh0000_0001;
   localparam comp_type NEG_LSB   = -32'sh0000_0001;
   localparam comp_type Q_HI      = 32'sh7fff_ffff;
   localparam comp_type Q_LO      = 32'sh8000_0000;
   localparam comp_type ROOT_HALF = 32'sd46341;
   localparam comp_type PAT_A     = 32'sh5555_5555;
   localparam comp_type PAT_B     = 32'shaaaa_aaaa;

   typedef struct packed {
      comp_type w;
      comp_type x;
      comp_type y;
      comp_type z;
   } fixed_quat_t;

   typedef struct packed {
      longint w;
      longint x;
      longint y;
      longint z;
   } wide_quat_t;

   logic     clock;
   logic     reset = 1'b1;
   logic     start = 1'b0;
   logic     busy;
   logic     req_op = OP_MUL;
   comp_type req_a_w = '0;
   comp_type req_a_x = '0;
   comp_type req_a_y = '0;
   comp_type req_a_z = '0;
   comp_type req_b_w = '0;
   comp_type req_b_x = '0;
   comp_type req_b_y = '0;
   comp_type req_b_z = '0;
   logic     rsp_valid;
   comp_type rsp_r_w;
   comp_type rsp_r_x;
   comp_type rsp_r_y;
   comp_type rsp_r_z;

   fixed_quat_t pending_results[$];
   int          mismatch_count = 0;
   int          idle_cycles = 0;

   quaternion_multiply_rotate #(
      .FRAC_BITS(FRAC)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_op    (req_op),
      .req_a_w   (req_a_w),
      .req_a_x   (req_a_x),
      .req_a_y   (req_a_y),
      .req_a_z   (req_a_z),
      .req_b_w   (req_b_w),
      .req_b_x   (req_b_x),
      .req_b_y   (req_b_y),
      .req_b_z   (req_b_z),
      .rsp_valid (rsp_valid),
      .rsp_r_w   (rsp_r_w),
      .rsp_r_x   (rsp_r_x),
      .rsp_r_y   (rsp_r_y),
      .rsp_r_z   (rsp_r_z)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // exact product, rounded to nearest with ties toward plus infinity
   function automatic longint round_product(longint p, longint q);
      longint s;
      s = p * q + (longint'(1) << (FRAC - 1));
      return s >>> FRAC;
   endfunction

   function automatic longint clamp_comp(longint v);
      if (v > 64'sd2147483647)
         return 64'sd2147483647;
      if (v < -64'sd2147483648)
         return -64'sd2147483648;
      return v;
   endfunction

   function automatic wide_quat_t hamilton_product(wide_quat_t p, wide_quat_t q);
      wide_quat_t r;
      r.w = clamp_comp(round_product(p.w, q.w) - round_product(p.x, q.x)
                     - round_product(p.y, q.y) - round_product(p.z, q.z));
      r.x = clamp_comp(round_product(p.w, q.x) + round_product(p.x, q.w)
                     + round_product(p.y, q.z) - round_product(p.z, q.y));
      r.y = clamp_comp(round_product(p.w, q.y) - round_product(p.x, q.z)
                     + round_product(p.y, q.w) + round_product(p.z, q.x));
      r.z = clamp_comp(round_product(p.w, q.z) + round_product(p.x, q.y)
                     - round_product(p.y, q.x) + round_product(p.z, q.w));
      return r;
   endfunction

   function automatic fixed_quat_t predict_quaternion(logic op, fixed_quat_t a, fixed_quat_t b);
      wide_quat_t  wa;
      wide_quat_t  wb;
      wide_quat_t  conj_b;
      wide_quat_t  r;
      fixed_quat_t res;
      wa.w = a.w;
      wa.x = a.x;
      wa.y = a.y;
      wa.z = a.z;
      wb.w = b.w;
      wb.x = b.x;
      wb.y = b.y;
      wb.z = b.z;
      if (op == OP_ROT) begin
         // negation is done wide so the most negative value does not wrap
         conj_b.w = wb.w;
         conj_b.x = -wb.x;
         conj_b.y = -wb.y;
         conj_b.z = -wb.z;
         r = hamilton_product(wb, hamilton_product(wa, conj_b));
      end else begin
         r = hamilton_product(wa, wb);
      end
      res.w = r.w[COMP_W-1:0];
      res.x = r.x[COMP_W-1:0];
      res.y = r.y[COMP_W-1:0];
      res.z = r.z[COMP_W-1:0];
      return res;
   endfunction

   function automatic comp_type random_comp();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         case ($urandom_range(0, 6))
            0: return Q_HI;
            1: return Q_LO;
            2: return ZERO;
            3: return NEG_LSB;
            4: return LSB;
            5: return ONE;
            default: return -ONE;
         endcase
      end
      if (pick <= 3)
         return $urandom;
      // mostly values within plus or minus four
      return int'($urandom_range(0, 524288)) - 262144;
   endfunction

   function automatic fixed_quat_t random_quat();
      fixed_quat_t q;
      q.w = random_comp();
      q.x = random_comp();
      q.y = random_comp();
      q.z = random_comp();
      return q;
   endfunction

   function automatic fixed_quat_t random_unit_quat();
      real         w;
      real         x;
      real         y;
      real         z;
      real         norm;
      real         scale;
      fixed_quat_t q;
      w = real'(int'($urandom_range(0, 2000)) - 1000) + 0.5;
      x = real'(int'($urandom_range(0, 2000)) - 1000);
      y = real'(int'($urandom_range(0, 2000)) - 1000);
      z = real'(int'($urandom_range(0, 2000)) - 1000);
      norm = $sqrt(w * w + x * x + y * y + z * z);
      scale = real'(longint'(1) << FRAC);
      q.w = $rtoi(w / norm * scale);
      q.x = $rtoi(x / norm * scale);
      q.y = $rtoi(y / norm * scale);
      q.z = $rtoi(z / norm * scale);
      return q;
   endfunction

   function automatic int next_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         return 0;
      if (pick < 88)
         return $urandom_range(1, 3);
      if (pick < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // start stays high into the next request when there is no gap
   task automatic send_request(logic op, fixed_quat_t a, fixed_quat_t b, int gap);
      req_op  <= op;
      req_a_w <= a.w;
      req_a_x <= a.x;
      req_a_y <= a.y;
      req_a_z <= a.z;
      req_b_w <= b.w;
      req_b_x <= b.x;
      req_b_y <= b.y;
      req_b_z <= b.z;
      start   <= 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic test_directed_cases();
      // zero, identity and the basis products
      send_request(OP_MUL, {ZERO, ZERO, ZERO, ZERO}, {ZERO, ZERO, ZERO, ZERO}, next_gap());
      send_request(OP_MUL, {ONE, ZERO, ZERO, ZERO}, {ONE + HALF, -2 * ONE, 3 * ONE, -(ONE >>> 2)},
                   next_gap());
      send_request(OP_MUL, {ZERO, ONE, ZERO, ZERO}, {ZERO, ZERO, ONE, ZERO}, next_gap());
      send_request(OP_MUL, {ZERO, ZERO, ONE, ZERO}, {ZERO, ZERO, ZERO, ONE}, next_gap());
      send_request(OP_MUL, {ZERO, ZERO, ZERO, ONE}, {ZERO, ONE, ZERO, ZERO}, next_gap());
      send_request(OP_MUL, {ZERO, ONE, ZERO, ZERO}, {ZERO, ONE, ZERO, ZERO}, next_gap());
      // rounding ties, positive and negative
      send_request(OP_MUL, {LSB, ZERO, ZERO, ZERO}, {HALF, ZERO, ZERO, ZERO}, next_gap());
      send_request(OP_MUL, {NEG_LSB, ZERO, ZERO, ZERO}, {HALF, ZERO, ZERO, ZERO}, next_gap());
      send_request(OP_MUL, {-32'sd3, LSB, NEG_LSB, ZERO}, {HALF, HALF, HALF, HALF}, next_gap());
      // saturation both ways
      send_request(OP_MUL, {Q_HI, Q_HI, Q_HI, Q_HI}, {Q_HI, Q_HI, Q_HI, Q_HI}, next_gap());
      send_request(OP_MUL, {Q_LO, Q_LO, Q_LO, Q_LO}, {Q_LO, Q_LO, Q_LO, Q_LO}, next_gap());
      send_request(OP_MUL, {Q_HI, Q_HI, Q_HI, Q_HI}, {Q_LO, Q_LO, Q_LO, Q_LO}, next_gap());
      send_request(OP_MUL, {Q_HI, Q_LO, Q_HI, Q_LO}, {Q_LO, Q_HI, Q_HI, Q_LO}, next_gap());
      send_request(OP_MUL, {NEG_LSB, NEG_LSB, NEG_LSB, NEG_LSB}, {PAT_A, PAT_B, PAT_A, PAT_B},
                   next_gap());
      send_request(OP_MUL, {PAT_B, PAT_A, PAT_B, PAT_A}, {PAT_A, PAT_B, PAT_B, PAT_A}, next_gap());
      // rotations: identity, quarter turn about z, half turn about x, non-unit scale
      send_request(OP_ROT, {ZERO, ONE, 2 * ONE, 3 * ONE}, {ONE, ZERO, ZERO, ZERO}, next_gap());
      send_request(OP_ROT, {ZERO, ONE, ZERO, ZERO}, {ROOT_HALF, ZERO, ZERO, ROOT_HALF},
                   next_gap());
      send_request(OP_ROT, {ZERO, ONE, 2 * ONE, 3 * ONE}, {ZERO, ONE, ZERO, ZERO}, next_gap());
      send_request(OP_ROT, {ZERO, ONE, -ONE, HALF}, {2 * ONE, ZERO, ZERO, ZERO}, next_gap());
      send_request(OP_ROT, {ZERO, ZERO, ZERO, ZERO}, {ZERO, ZERO, ZERO, ZERO}, next_gap());
      // conjugate of the most negative component
      send_request(OP_ROT, {Q_LO, Q_LO, Q_LO, Q_LO}, {Q_LO, Q_LO, Q_LO, Q_LO}, next_gap());
      send_request(OP_ROT, {ZERO, ONE, ONE, ONE}, {ZERO, Q_LO, ZERO, ZERO}, next_gap());
      send_request(OP_ROT, {Q_HI, Q_HI, Q_HI, Q_HI}, {Q_HI, Q_HI, Q_HI, Q_HI}, next_gap());
      send_request(OP_ROT, {Q_HI, Q_LO, Q_HI, Q_LO}, {HALF, NEG_LSB, LSB, HALF}, next_gap());
      send_request(OP_ROT, {PAT_A, PAT_B, PAT_A, PAT_B}, {PAT_B, PAT_A, PAT_B, PAT_A}, next_gap());
   endtask

   task automatic test_random_multiply(int count);
      repeat (count)
         send_request(OP_MUL, random_quat(), random_quat(), next_gap());
   endtask

   // mostly vectors turned by unit quaternions, some with a scalar part, some noise
   task automatic test_random_rotate(int count);
      fixed_quat_t a;
      fixed_quat_t b;
      int          pick;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         a = random_quat();
         b = (pick < 85) ? random_unit_quat() : random_quat();
         if (pick < 70)
            a.w = ZERO;
         send_request(OP_ROT, a, b, next_gap());
      end
   endtask

   // first half back to back, then with gaps
   task automatic test_mixed_stream(int count);
      int n;
      for (n = 0; n < count; n++)
         send_request($urandom_range(0, 1) ? OP_ROT : OP_MUL,
                      random_quat(), random_quat(), (n < count / 2) ? 0 : next_gap());
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_multiply(250);
      test_random_rotate(250);
      test_mixed_stream(200);
      start <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   always @(posedge clock) begin : check_results
      fixed_quat_t want;
      fixed_quat_t got;
      if (!reset) begin
         if (start && !busy)
            pending_results.push_back(predict_quaternion(req_op,
               {req_a_w, req_a_x, req_a_y, req_a_z}, {req_b_w, req_b_x, req_b_y, req_b_z}));
         if (rsp_valid) begin
            got = {rsp_r_w, rsp_r_x, rsp_r_y, rsp_r_z};
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result %0d %0d %0d %0d", got.w, got.x, got.y, got.z);
            end else begin
               want = pending_results.pop_front();
               if (want.w != got.w || want.x != got.x || want.y != got.y || want.z != got.z) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected w %0d x %0d y %0d z %0d, got w %0d x %0d y %0d z %0d",
                              want.w, want.x, want.y, want.z, got.w, got.x, got.y, got.z);
               end
            end
         end
      end
   end

   // a request or a result must move within the limit
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/qmr_pkg.sv
rtl/core/qmr_hamilton.sv
rtl/core/quaternion_multiply_rotate.sv
verif/quaternion_multiply_rotate_tb.sv
